/* rtl/core/session_token_guard_table_assert.svh */
// Assertion macros used by the checker file of the session table.
`ifndef SESSION_TOKEN_GUARD_TABLE_ASSERT_SVH
`define SESSION_TOKEN_GUARD_TABLE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define STG_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define STG_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

/* rtl/core/stg_pkg.sv */
// ----------------------------------------------------------------------------
// Session table package
// Shared types and constants of the session token guard table.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam logic [1:0] OP_CREATE   = 2'd0;
  localparam logic [1:0] OP_VALIDATE = 2'd1;
  localparam logic [1:0] OP_REVOKE   = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  localparam logic [1:0] ST_EXPIRED = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_HIJACK  = 2'd2;
  localparam logic [1:0] ST_OTHER   = 2'd3;

  localparam logic [2:0] RC_OK         = 3'd0;
  localparam logic [2:0] RC_FULL       = 3'd1;
  localparam logic [2:0] RC_NOT_FOUND  = 3'd2;
  localparam logic [2:0] RC_NOT_VALID  = 3'd3;
  localparam logic [2:0] RC_TOKEN      = 3'd4;
  localparam logic [2:0] RC_PROCESS    = 3'd5;
  localparam logic [2:0] RC_CAPABILITY = 3'd6;

  localparam logic [63:0] MASK_HIGH   = 64'hA5A5A5A5A5A5A5A5;
  localparam logic [63:0] MASK_LOW    = 64'h5A5A5A5A5A5A5A5A;
  localparam logic [31:0] FIRST_ID    = 32'd1000;
  localparam logic [3:0]  LIMIT_RESET = 4'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] session_number;
    logic [31:0] process_id;
    logic [31:0] capability_mask;
    logic [63:0] token_high;
    logic [63:0] token_low;
    logic        token_present;
    logic [63:0] entropy_high;
    logic [63:0] entropy_low;
    logic [1:0]  revoke_status;
  } stg_in_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [31:0] issued_session;
    logic [3:0]  issued_slot;
    logic [63:0] issued_token_high;
    logic [63:0] issued_token_low;
    logic [4:0]  active_count;
    logic [4:0]  anomaly_count;
    logic [31:0] blocked_total;
  } stg_out_t;

  // One slot's contents as it travels around the ring.
  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  status;
    logic [31:0] owner;
    logic [31:0] caps;
    logic [63:0] secret_high;
    logic [63:0] secret_low;
    logic [3:0]  attempts;
  } stg_slot_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic load;
  } stg_ctl_t;

endpackage

/* rtl/core/stg_cell.sv */
// ----------------------------------------------------------------------------
// Session slot cell
// Holds one slot and passes it to the next cell on each shift.
// ----------------------------------------------------------------------------
module stg_cell (
  input  logic              clk,
  input  logic              rst,
  input  stg_pkg::stg_ctl_t ctl,
  input  stg_pkg::stg_slot_t slot_in,
  output stg_pkg::stg_slot_t slot_out
);
  import stg_pkg::*;

  stg_slot_t slot;

  // Control fields reset; payload fields do not.
  always_ff @(posedge clk) begin
    if (ctl.shift || ctl.load) begin
      slot.owner       <= slot_in.owner;
      slot.caps        <= slot_in.caps;
      slot.secret_high <= slot_in.secret_high;
      slot.secret_low  <= slot_in.secret_low;
    end
    if (rst) begin
      slot.id       <= '0;
      slot.status   <= ST_EXPIRED;
      slot.attempts <= '0;
    end else if (ctl.shift || ctl.load) begin
      slot.id       <= slot_in.id;
      slot.status   <= slot_in.status;
      slot.attempts <= slot_in.attempts;
    end
  end

  assign slot_out = slot;
endmodule

/* rtl/core/stg_engine.sv */
// ----------------------------------------------------------------------------
// Session operation engine
// Examines the slot at the head of the ring each cycle of a walk and applies the item.
// ----------------------------------------------------------------------------
module stg_engine #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  stg_pkg::stg_in_t   item,
  input  logic [3:0]         hijack_limit,
  input  stg_pkg::stg_slot_t head,
  output stg_pkg::stg_slot_t head_new,
  output stg_pkg::stg_ctl_t  ctl,
  output logic               done,
  output stg_pkg::stg_out_t  result
);
  import stg_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t         state;
  stg_in_t        req;
  logic [IW-1:0]  index;
  logic           hit;
  logic [31:0]    next_id;
  logic [31:0]    blocked;
  logic [4:0]     active;
  logic [4:0]     anomaly;
  stg_out_t       res;
  logic           match;
  logic           take;
  logic           bump;
  logic [2:0]     code_next;
  logic [3:0]     att_inc;
  logic [4:0]     active_next;
  logic [4:0]     anomaly_next;
  logic           last;

  assign busy = (state != S_IDLE);
  assign last = (index == IW'(SLOTS - 1));
  assign att_inc = (head.attempts == 4'd15) ? head.attempts : head.attempts + 4'd1;

  // Per-slot decision on the slot now at the head of the ring.
  always_comb begin
    head_new  = head;
    match     = 1'b0;
    take      = 1'b0;
    bump      = 1'b0;
    code_next = res.result_code;
    case (req.operation)
      OP_CREATE: begin
        if (!hit && (head.status == ST_EXPIRED || head.id == '0)) begin
          take                 = 1'b1;
          head_new.id          = next_id;
          head_new.owner       = req.process_id;
          head_new.caps        = req.capability_mask;
          head_new.secret_high = req.entropy_high ^ MASK_HIGH;
          head_new.secret_low  = req.entropy_low ^ MASK_LOW;
          head_new.status      = ST_VALID;
          head_new.attempts    = '0;
          code_next            = RC_OK;
        end
      end
      OP_VALIDATE: begin
        if (!hit && head.id == req.session_number) begin
          match = 1'b1;
          if (head.status != ST_VALID) begin
            code_next = RC_NOT_VALID;
          end else if (!req.token_present || head.secret_high != req.token_high ||
                       head.secret_low != req.token_low) begin
            bump              = 1'b1;
            head_new.attempts = att_inc;
            if (att_inc >= hijack_limit) begin
              head_new.status = ST_HIJACK;
            end
            code_next = RC_TOKEN;
          end else if (head.owner != req.process_id && head.owner != '0) begin
            bump              = 1'b1;
            head_new.attempts = att_inc;
            head_new.status   = ST_HIJACK;
            code_next         = RC_PROCESS;
          end else if ((head.caps & req.capability_mask) != req.capability_mask) begin
            code_next = RC_CAPABILITY;
          end else begin
            code_next = RC_OK;
          end
        end
      end
      OP_REVOKE: begin
        if (!hit && head.id == req.session_number) begin
          match                = 1'b1;
          head_new.status      = req.revoke_status;
          head_new.secret_high = '0;
          head_new.secret_low  = '0;
          code_next            = RC_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Running counts over the updated slots.
  always_comb begin
    active_next  = active;
    anomaly_next = anomaly;
    if (head_new.id != '0) begin
      if (head_new.status == ST_VALID && active != 5'd31) begin
        active_next = active + 5'd1;
      end else if (head_new.status == ST_HIJACK && anomaly != 5'd31) begin
        anomaly_next = anomaly + 5'd1;
      end
    end
  end

  assign ctl.shift = (state == S_WALK);
  assign ctl.load  = 1'b0;

  // Sequencer: one slot per cycle, a full turn of the ring per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      index   <= '0;
      hit     <= 1'b0;
      next_id <= FIRST_ID;
      blocked <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state   <= S_WALK;
            req     <= item;
            index   <= '0;
            hit     <= 1'b0;
            active  <= '0;
            anomaly <= '0;
            res     <= '0;
            case (item.operation)
              OP_CREATE:   res.result_code <= RC_FULL;
              OP_VALIDATE: res.result_code <= RC_NOT_FOUND;
              OP_REVOKE:   res.result_code <= RC_NOT_FOUND;
              default:     res.result_code <= RC_OK;
            endcase
          end
        end
        S_WALK: begin
          active  <= active_next;
          anomaly <= anomaly_next;
          if (take || match) begin
            hit                 <= 1'b1;
            res.result_code     <= code_next;
            res.issued_slot     <= 4'(index);
          end
          if (take) begin
            next_id                <= next_id + 32'd1;
            res.issued_session     <= next_id;
            res.issued_token_high  <= head_new.secret_high;
            res.issued_token_low   <= head_new.secret_low;
          end
          if (bump) begin
            blocked <= blocked + 32'd1;
          end
          index <= index + IW'(1);
          if (last) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    result               = res;
    result.active_count  = active;
    result.anomaly_count = anomaly;
    result.blocked_total = blocked;
  end
endmodule

/* rtl/core/session_token_guard_table.sv */
// An item is accepted only while busy is low; busy stays high during the walk,
// so the block takes no new item until the current one has finished.
// The walk turns the slot ring once, one cell per cycle, through one engine.
// Reset clears all ids, statuses, attempt counters, the id counter and total.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Session token guard table
// A ring of slot cells walked by a single operation engine.
// ----------------------------------------------------------------------------
module session_token_guard_table #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  stg_pkg::stg_in_t  in_item,
  output logic              out_strobe,
  output stg_pkg::stg_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);
  import stg_pkg::*;

  stg_slot_t chain [SLOTS+1];
  stg_slot_t head_new;
  stg_ctl_t  ctl;
  logic [3:0] hijack_limit;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      hijack_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hijack_limit <= cfg_data;
    end
  end

  // The engine output feeds the last cell; cell 0 is the head.
  assign chain[SLOTS] = head_new;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    stg_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .slot_in (chain[g+1]),
      .slot_out(chain[g])
    );
  end

  stg_engine #(.SLOTS(SLOTS)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (in_item),
    .hijack_limit(hijack_limit),
    .head        (chain[0]),
    .head_new    (head_new),
    .ctl         (ctl),
    .done        (out_strobe),
    .result      (out_item)
  );
endmodule

/* rtl/core/stg_checker.sv */
// ----------------------------------------------------------------------------
// Session table checker
// Port-level checks on the session table, bound to the top level.
// ----------------------------------------------------------------------------
`include "session_token_guard_table_assert.svh"

module stg_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input stg_pkg::stg_out_t out_item
);
  import stg_pkg::*;

  // An accepted item makes the block busy.
  `STG_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  // A result appears only at the end of a walk.
  `STG_ASSERT_IMP(a_strobe_idle, clk, rst, out_strobe, !busy && $past(busy))
  // A result never comes in consecutive cycles.
  `STG_ASSERT_NEXT(a_strobe_single, clk, rst, out_strobe, !out_strobe)
  // A result other than OK issues no session.
  `STG_ASSERT_IMP(a_issue_ok, clk, rst, out_strobe && out_item.result_code != RC_OK,
    out_item.issued_session == '0)
endmodule

bind session_token_guard_table stg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_item  (out_item)
);

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Session table testbench
// Drives create, validate, revoke and query items into the session table,
// predicts each result with a behavioral copy of the table and compares the
// strobed results field by field. Covers the hijack limit settings too.
// ----------------------------------------------------------------------------
module testbench;
  import stg_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  stg_in_t  in_item = '0;
  logic     out_strobe;
  stg_out_t out_item;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [3:0] cfg_data = '0;

  session_token_guard_table #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted table contents.
  logic [31:0] tbl_id [NSLOT];
  logic [1:0]  tbl_status [NSLOT];
  logic [31:0] tbl_owner [NSLOT];
  logic [31:0] tbl_caps [NSLOT];
  logic [63:0] tbl_sec_hi [NSLOT];
  logic [63:0] tbl_sec_lo [NSLOT];
  logic [3:0]  tbl_tries [NSLOT];
  bit          tbl_filled [NSLOT];
  logic [31:0] id_counter;
  logic [31:0] blocked_sum;
  logic [3:0]  limit_reg;

  stg_out_t pending_results[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       quiet = 1'b0;

  // Ids handed out so far, used to aim validates and revokes.
  logic [31:0] known_ids[$];
  logic [63:0] known_hi[$];
  logic [63:0] known_lo[$];
  logic [31:0] known_pid[$];
  logic [31:0] known_caps[$];

  function automatic int find_session(logic [31:0] sid);
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_id[i] == sid) return i;
    end
    return -1;
  endfunction

  function automatic void note_attempt(int i);
    if (tbl_tries[i] != 4'd15) tbl_tries[i]++;
    blocked_sum++;
  endfunction

  // Works out the result of one item and updates the predicted table.
  function automatic stg_out_t predict_session(stg_in_t it);
    stg_out_t r;
    int i;
    r = '0;
    r.result_code = RC_OK;
    case (it.operation)
      OP_CREATE: begin
        r.result_code = RC_FULL;
        for (i = 0; i < NSLOT; i++) begin
          if (tbl_status[i] == ST_EXPIRED || tbl_id[i] == 0) begin
            tbl_id[i] = id_counter;
            r.issued_session = id_counter;
            id_counter++;
            tbl_owner[i] = it.process_id;
            tbl_caps[i] = it.capability_mask;
            tbl_sec_hi[i] = it.entropy_high ^ MASK_HIGH;
            tbl_sec_lo[i] = it.entropy_low ^ MASK_LOW;
            tbl_status[i] = ST_VALID;
            tbl_tries[i] = '0;
            tbl_filled[i] = 1'b1;
            r.issued_token_high = tbl_sec_hi[i];
            r.issued_token_low = tbl_sec_lo[i];
            r.issued_slot = i[3:0];
            r.result_code = RC_OK;
            break;
          end
        end
      end
      OP_VALIDATE: begin
        i = find_session(it.session_number);
        if (i < 0) begin
          r.result_code = RC_NOT_FOUND;
        end else begin
          r.issued_slot = i[3:0];
          if (tbl_status[i] != ST_VALID) begin
            r.result_code = RC_NOT_VALID;
          end else if (!it.token_present || tbl_sec_hi[i] != it.token_high ||
                       tbl_sec_lo[i] != it.token_low) begin
            note_attempt(i);
            if (tbl_tries[i] >= limit_reg) tbl_status[i] = ST_HIJACK;
            r.result_code = RC_TOKEN;
          end else if (tbl_owner[i] != it.process_id && tbl_owner[i] != 0) begin
            note_attempt(i);
            tbl_status[i] = ST_HIJACK;
            r.result_code = RC_PROCESS;
          end else if ((tbl_caps[i] & it.capability_mask) != it.capability_mask) begin
            r.result_code = RC_CAPABILITY;
          end
        end
      end
      OP_REVOKE: begin
        i = find_session(it.session_number);
        if (i < 0) begin
          r.result_code = RC_NOT_FOUND;
        end else begin
          r.issued_slot = i[3:0];
          tbl_status[i] = it.revoke_status;
          tbl_sec_hi[i] = '0;
          tbl_sec_lo[i] = '0;
        end
      end
      default: ;
    endcase
    for (i = 0; i < NSLOT; i++) begin
      if (tbl_id[i] != 0) begin
        if (tbl_status[i] == ST_VALID) r.active_count++;
        else if (tbl_status[i] == ST_HIJACK) r.anomaly_count++;
      end
    end
    r.blocked_total = blocked_sum;
    return r;
  endfunction

  // A validate that would reach the owner check of a never-created slot is
  // outside the contract, so such items are turned into queries.
  function automatic stg_in_t make_legal(stg_in_t it);
    int i;
    if (it.operation == OP_VALIDATE) begin
      i = find_session(it.session_number);
      if (i >= 0 && !tbl_filled[i] && tbl_status[i] == ST_VALID) it.operation = OP_QUERY;
    end
    return it;
  endfunction

  // Cycle counter and result checker.
  always @(posedge clk) begin
    stg_out_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.result_code !== exp_r.result_code) begin
          $error("result_code exp %0d got %0d", exp_r.result_code, out_item.result_code);
          fail_count++;
        end
        if (out_item.issued_session !== exp_r.issued_session) begin
          $error("issued_session exp %0d got %0d", exp_r.issued_session,
                 out_item.issued_session);
          fail_count++;
        end
        if (out_item.issued_slot !== exp_r.issued_slot) begin
          $error("issued_slot exp %0d got %0d", exp_r.issued_slot, out_item.issued_slot);
          fail_count++;
        end
        if (out_item.issued_token_high !== exp_r.issued_token_high) begin
          $error("issued_token_high exp %h got %h", exp_r.issued_token_high,
                 out_item.issued_token_high);
          fail_count++;
        end
        if (out_item.issued_token_low !== exp_r.issued_token_low) begin
          $error("issued_token_low exp %h got %h", exp_r.issued_token_low,
                 out_item.issued_token_low);
          fail_count++;
        end
        if (out_item.active_count !== exp_r.active_count) begin
          $error("active_count exp %0d got %0d", exp_r.active_count, out_item.active_count);
          fail_count++;
        end
        if (out_item.anomaly_count !== exp_r.anomaly_count) begin
          $error("anomaly_count exp %0d got %0d", exp_r.anomaly_count,
                 out_item.anomaly_count);
          fail_count++;
        end
        if (out_item.blocked_total !== exp_r.blocked_total) begin
          $error("blocked_total exp %0d got %0d", exp_r.blocked_total,
                 out_item.blocked_total);
          fail_count++;
        end
      end
    end
  end

  // Sends one item; an optional typed-in expectation overrides the prediction.
  task automatic send_item(stg_in_t it, bit has_fixed, stg_out_t fixed);
    stg_out_t p;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    it = make_legal(it);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    p = predict_session(it);
    if (has_fixed && p != fixed) begin
      $error("directed row disagrees with predictor: result_code exp %0d got %0d",
             fixed.result_code, p.result_code);
      fail_count++;
    end
    pending_results.push_back(has_fixed ? fixed : p);
    if (it.operation == OP_CREATE && p.result_code == RC_OK) begin
      known_ids.push_back(p.issued_session);
      known_hi.push_back(p.issued_token_high);
      known_lo.push_back(p.issued_token_low);
      known_pid.push_back(it.process_id);
      known_caps.push_back(it.capability_mask);
    end
    // The block is busy now; step off the accepting edge before the next item.
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NSLOT + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  function automatic stg_in_t rand_item();
    stg_in_t it;
    int k;
    it.operation = 2'($urandom_range(0, 3));
    it.session_number = $urandom();
    it.process_id = $urandom();
    it.capability_mask = $urandom();
    it.token_high = {$urandom(), $urandom()};
    it.token_low = {$urandom(), $urandom()};
    it.token_present = 1'($urandom_range(0, 1));
    it.entropy_high = {$urandom(), $urandom()};
    it.entropy_low = {$urandom(), $urandom()};
    it.revoke_status = 2'($urandom_range(0, 3));
    // Mostly aim at issued sessions with the right token and owner.
    if (known_ids.size() != 0 && $urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, known_ids.size() - 1);
      if ($urandom_range(0, 7) == 0) k = known_ids.size() - 1;
      it.session_number = known_ids[k];
      if ($urandom_range(0, 3) != 0) begin
        it.token_high = known_hi[k];
        it.token_low = known_lo[k];
        it.token_present = ($urandom_range(0, 9) != 0);
      end
      if ($urandom_range(0, 3) != 0) it.process_id = known_pid[k];
      if ($urandom_range(0, 2) != 0) it.capability_mask = known_caps[k] & $urandom();
      if (it.operation == OP_REVOKE && $urandom_range(0, 1) == 0)
        it.revoke_status = ST_EXPIRED;
    end
    return it;
  endfunction

  typedef struct {
    stg_in_t  it;
    bit       fixed;
    stg_out_t want;
  } row_t;

  initial begin
    row_t rows[$];
    row_t r;
    stg_in_t it;
    stg_out_t o;
    int k;
    logic [3:0] limits[5] = '{4'd1, 4'd15, 4'd2, 4'd7, 4'd3};

    for (int i = 0; i < NSLOT; i++) begin
      tbl_id[i] = '0; tbl_status[i] = ST_EXPIRED; tbl_owner[i] = '0; tbl_caps[i] = '0;
      tbl_sec_hi[i] = '0; tbl_sec_lo[i] = '0; tbl_tries[i] = '0; tbl_filled[i] = 1'b0;
    end
    id_counter = FIRST_ID;
    blocked_sum = '0;
    limit_reg = LIMIT_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: query after reset, misses, creates with extreme fields.
    it = '0; it.operation = OP_QUERY;
    r.it = it; r.fixed = 1'b1; r.want = '0; rows.push_back(r);
    it.operation = OP_VALIDATE; it.session_number = '1;
    r.it = it; r.want = '0; r.want.result_code = RC_NOT_FOUND; rows.push_back(r);
    it.operation = OP_REVOKE; it.session_number = 32'd5;
    r.it = it; r.want = '0; r.want.result_code = RC_NOT_FOUND; rows.push_back(r);
    it = '1; it.operation = OP_CREATE;
    r.it = it; r.want = '0; r.want.issued_session = FIRST_ID;
    r.want.issued_token_high = ~MASK_HIGH; r.want.issued_token_low = ~MASK_LOW;
    r.want.active_count = 5'd1; rows.push_back(r);
    it = '0; it.operation = OP_CREATE; it.process_id = 32'd0;
    r.it = it; r.want = '0; r.want.issued_session = FIRST_ID + 1;
    r.want.issued_slot = 4'd1;
    r.want.issued_token_high = MASK_HIGH; r.want.issued_token_low = MASK_LOW;
    r.want.active_count = 5'd2; rows.push_back(r);
    r.fixed = 1'b0;
    // Good validate on the wildcard owner, capability failure, process mismatch.
    it = '0; it.operation = OP_VALIDATE; it.session_number = FIRST_ID + 1;
    it.token_present = 1; it.token_high = MASK_HIGH; it.token_low = MASK_LOW;
    it.process_id = 32'h1234;
    r.it = it; rows.push_back(r);
    it.capability_mask = 32'h1; r.it = it; rows.push_back(r);
    it = '0; it.operation = OP_VALIDATE; it.session_number = FIRST_ID;
    it.token_present = 1; it.token_high = ~MASK_HIGH; it.token_low = ~MASK_LOW;
    it.process_id = '1; it.capability_mask = '1; r.it = it; rows.push_back(r);
    it.process_id = 32'd7; r.it = it; rows.push_back(r);
    it.process_id = '1; r.it = it; rows.push_back(r);
    // Token absent and wrong token up to the hijack limit.
    it = '0; it.operation = OP_VALIDATE; it.session_number = FIRST_ID + 1;
    it.token_high = MASK_HIGH; it.token_low = MASK_LOW;
    r.it = it; rows.push_back(r);
    it.token_present = 1; it.token_low = 64'd0; r.it = it; rows.push_back(r);
    r.it = it; rows.push_back(r);
    r.it = it; rows.push_back(r);
    // Revoke to each status, then refill the expired slot.
    it = '0; it.operation = OP_REVOKE; it.session_number = FIRST_ID;
    it.revoke_status = ST_OTHER; r.it = it; rows.push_back(r);
    it.revoke_status = ST_HIJACK; r.it = it; rows.push_back(r);
    it.revoke_status = ST_VALID; r.it = it; rows.push_back(r);
    it.revoke_status = ST_EXPIRED; r.it = it; rows.push_back(r);
    it = '0; it.operation = OP_CREATE; it.process_id = 32'h55; it.capability_mask = '1;
    r.it = it; rows.push_back(r);
    foreach (rows[j]) send_item(rows[j].it, rows[j].fixed, rows[j].want);
    drain();

    // Fill the table to reach the full code.
    for (int j = 0; j < NSLOT + 2; j++) begin
      it = rand_item(); it.operation = OP_CREATE; send_item(it, 0, o);
    end
    drain();

    // Random phases over several hijack limits, one pause per phase.
    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (p == 4) quiet = 1'b1;
      for (int j = 0; j < 105; j++) begin
        it = rand_item();
        if (j % 25 == 0) begin
          it.operation = OP_CREATE;
        end
        // Once per phase, expire every known session so creates keep finding room.
        if (j == 60) begin
          for (k = 0; k < known_ids.size(); k++) begin
            it = '0; it.operation = OP_REVOKE; it.session_number = known_ids[k];
            if (find_session(known_ids[k]) >= 0) send_item(it, 0, o);
          end
          known_ids.delete(); known_hi.delete(); known_lo.delete();
          known_pid.delete(); known_caps.delete();
          it = rand_item();
        end
        send_item(it, 0, o);
      end
      drain();
    end

    // Id wrap check: reach the top of the id space by many creates is too
    // slow, so it is covered only through the predictor's 32-bit counter.
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
